### src/atad_pkg.sv
package atad_pkg;

    // sample and field widths
    localparam int SAMPLE_BITS  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int FIELD_W      = 16;
    localparam int DUTY_W       = 16;
    localparam int TILT_W       = 15;

    // magnitude path
    localparam int ABS_W    = SAMPLE_BITS;
    localparam int SQ_W     = 2 * SAMPLE_BITS;
    localparam int SUM_W    = SQ_W + 1;      // x^2 + z^2
    localparam int MAG_W    = SQ_W + 2;      // x^2 + y^2 + z^2
    localparam int NORM_TOP = 60;            // normalize magnitude to >= 2^60
    localparam int NORM_W   = NORM_TOP + 2;
    localparam int SHIFT_W  = 5;             // k <= NORM_TOP/2
    localparam int ROOT_W   = NORM_W / 2;
    localparam int ROOT_STEPS = NORM_W / 2;  // one root bit per stage

    // CORDIC
    localparam int TABLE_LEN = 24;
    localparam int STEPS = (CORDIC_STEPS < 1) ? 1 :
                           ((CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS);
    localparam int XY_W  = ROOT_W + 3;
    localparam int ANG_W = 35;               // angle in 1e-8 degree

    // centidegree rounding: floor((a + 5e5) / 1e6) = floor(floor((a + 5e5) / 64) / 15625)
    localparam int  UNITS_HALF = 500000;
    localparam int  PRE_SHIFT  = 6;
    localparam int  DIV_Q_W    = ANG_W + 1 - PRE_SHIFT;
    localparam int  MUL_W      = 29;
    localparam logic [MUL_W-1:0] DIV_MUL = 29'd281474977;   // ceil(2^42 / 15625)
    localparam int  DIV_SHIFT  = 42;
    localparam int  PROD_W     = DIV_Q_W + MUL_W;
    localparam int  CD_W       = PROD_W - DIV_SHIFT;
    localparam int  MAX_CENTIDEG = 9000;
    localparam logic signed [TILT_W-1:0] TILT_MAX = 15'sd9000;
    localparam logic signed [TILT_W-1:0] TILT_MIN = -15'sd9000;
    localparam logic [DUTY_W:0]          DUTY_FULL = 17'd32768;

    // duty scaling to 15 fraction bits
    localparam int DUTY_SHR = (SAMPLE_BITS >= 16) ? SAMPLE_BITS - 16 : 0;
    localparam int DUTY_SHL = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;

    typedef struct packed {
        logic              neg;
        logic              ay_zero;
        logic              s_zero;
        logic [DUTY_W-1:0] duty_x;
        logic [DUTY_W-1:0] duty_y;
        logic [DUTY_W-1:0] duty_z;
    } t_side;

    function automatic logic [ABS_W-1:0] abs_of(input logic [SAMPLE_BITS-1:0] v);
        logic [ABS_W-1:0] a;
        a = v[SAMPLE_BITS-1] ? ABS_W'(~v + 1'b1) : ABS_W'(v);
        return a;
    endfunction

    function automatic logic [DUTY_W-1:0] duty_of(input logic [ABS_W-1:0] a);
        logic [31:0] t;
        t = (32'(a) << DUTY_SHL) >> DUTY_SHR;
        return t[DUTY_W-1:0];
    endfunction

    // atan(2^-i) in 1e-8 degree
    function automatic logic signed [ANG_W-1:0] atan_entry(input int unsigned idx);
        logic signed [ANG_W-1:0] v;
        unique case (idx)
            0:  v = 35'sd4500000000;
            1:  v = 35'sd2656505118;
            2:  v = 35'sd1403624347;
            3:  v = 35'sd712501635;
            4:  v = 35'sd357633437;
            5:  v = 35'sd178991061;
            6:  v = 35'sd89517371;
            7:  v = 35'sd44761417;
            8:  v = 35'sd22381050;
            9:  v = 35'sd11190568;
            10: v = 35'sd5595289;
            11: v = 35'sd2797645;
            12: v = 35'sd1398823;
            13: v = 35'sd699411;
            14: v = 35'sd349706;
            15: v = 35'sd174853;
            16: v = 35'sd87426;
            17: v = 35'sd43713;
            18: v = 35'sd21857;
            19: v = 35'sd10928;
            20: v = 35'sd5464;
            21: v = 35'sd2732;
            22: v = 35'sd1366;
            23: v = 35'sd683;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### src/atad_ifs.sv
interface atad_in_if;
    import atad_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] accel_x;
    logic signed [FIELD_W-1:0] accel_y;
    logic signed [FIELD_W-1:0] accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

interface atad_out_if;
    import atad_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TILT_W-1:0] tilt_centideg;
    logic [DUTY_W-1:0]        duty_x;
    logic [DUTY_W-1:0]        duty_y;
    logic [DUTY_W-1:0]        duty_z;

    modport source (output valid, output tilt_centideg, output duty_x, output duty_y,
                    output duty_z, input ready);
    modport sink   (input valid, input tilt_centideg, input duty_x, input duty_y,
                    input duty_z, output ready);
endinterface

### src/atad_isqrt.sv
module atad_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  atad_pkg::t_side               i_side,
    input  logic [atad_pkg::NORM_W-1:0]   i_n,
    input  logic [atad_pkg::ROOT_W-1:0]   i_y,
    output logic                          o_valid,
    output atad_pkg::t_side               o_side,
    output logic [atad_pkg::ROOT_W-1:0]   o_root,
    output logic [atad_pkg::ROOT_W-1:0]   o_y
);
    import atad_pkg::*;

    logic              r_valid [ROOT_STEPS];
    t_side             r_side  [ROOT_STEPS];
    logic [NORM_W-1:0] r_rem   [ROOT_STEPS];
    logic [NORM_W-1:0] r_res   [ROOT_STEPS];
    logic [ROOT_W-1:0] r_y     [ROOT_STEPS];

    // restoring square root, one result bit per stage, bit = 4^(ROOT_STEPS-1-j)
    for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_stage
        localparam logic [NORM_W-1:0] BIT = NORM_W'(1) << (NORM_W - 2 - 2 * j);

        logic              w_valid;
        t_side             w_side;
        logic [NORM_W-1:0] w_rem;
        logic [NORM_W-1:0] w_res;
        logic [ROOT_W-1:0] w_y;
        logic [NORM_W:0]   w_trial;
        logic              w_ge;
        logic [NORM_W:0]   w_diff;
        logic [NORM_W-1:0] n_rem;
        logic [NORM_W-1:0] n_res;

        if (j == 0) begin : g_src
            assign w_valid = i_valid;
            assign w_side  = i_side;
            assign w_rem   = i_n;
            assign w_res   = '0;
            assign w_y     = i_y;
        end else begin : g_src
            assign w_valid = r_valid[j-1];
            assign w_side  = r_side[j-1];
            assign w_rem   = r_rem[j-1];
            assign w_res   = r_res[j-1];
            assign w_y     = r_y[j-1];
        end

        always_comb begin
            w_trial = {1'b0, w_res} + {1'b0, BIT};
            w_ge    = {1'b0, w_rem} >= w_trial;
            w_diff  = {1'b0, w_rem} - w_trial;
            n_rem   = w_ge ? w_diff[NORM_W-1:0] : w_rem;
            n_res   = w_ge ? (w_res >> 1) + BIT : (w_res >> 1);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[j] <= w_side;
                r_rem[j]  <= n_rem;
                r_res[j]  <= n_res;
                r_y[j]    <= w_y;
            end
        end
    end

    assign o_valid = r_valid[ROOT_STEPS-1];
    assign o_side  = r_side[ROOT_STEPS-1];
    assign o_root  = r_res[ROOT_STEPS-1][ROOT_W-1:0];
    assign o_y     = r_y[ROOT_STEPS-1];

endmodule

### src/atad_cordic.sv
module atad_cordic (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  atad_pkg::t_side                    i_side,
    input  logic [atad_pkg::ROOT_W-1:0]        i_root,
    input  logic [atad_pkg::ROOT_W-1:0]        i_y,
    output logic                               o_valid,
    output atad_pkg::t_side                    o_side,
    output logic signed [atad_pkg::ANG_W-1:0]  o_angle
);
    import atad_pkg::*;

    logic                    r_valid [STEPS];
    t_side                   r_side  [STEPS];
    logic signed [XY_W-1:0]  r_cx    [STEPS];
    logic signed [XY_W-1:0]  r_cy    [STEPS];
    logic signed [ANG_W-1:0] r_acc   [STEPS];

    // vectoring mode: drive cy toward zero, angle gathered in r_acc
    for (genvar i = 0; i < STEPS; i++) begin : g_stage
        localparam logic signed [ANG_W-1:0] ATAN_I = atan_entry(i);

        logic                    w_valid;
        t_side                   w_side;
        logic signed [XY_W-1:0]  w_cx;
        logic signed [XY_W-1:0]  w_cy;
        logic signed [ANG_W-1:0] w_acc;
        logic signed [XY_W-1:0]  w_dx;
        logic signed [XY_W-1:0]  w_dy;
        logic                    w_pos;
        logic signed [XY_W-1:0]  n_cx;
        logic signed [XY_W-1:0]  n_cy;
        logic signed [ANG_W-1:0] n_acc;

        if (i == 0) begin : g_src
            assign w_valid = i_valid;
            assign w_side  = i_side;
            assign w_cx    = $signed({{(XY_W - ROOT_W){1'b0}}, i_root});
            assign w_cy    = $signed({{(XY_W - ROOT_W){1'b0}}, i_y});
            assign w_acc   = '0;
        end else begin : g_src
            assign w_valid = r_valid[i-1];
            assign w_side  = r_side[i-1];
            assign w_cx    = r_cx[i-1];
            assign w_cy    = r_cy[i-1];
            assign w_acc   = r_acc[i-1];
        end

        always_comb begin
            w_dx  = w_cy >>> i;
            w_dy  = w_cx >>> i;
            w_pos = !w_cy[XY_W-1] && (w_cy != '0);
            if (w_pos) begin
                n_cx  = w_cx + w_dx;
                n_cy  = w_cy - w_dy;
                n_acc = w_acc + ATAN_I;
            end else begin
                n_cx  = w_cx - w_dx;
                n_cy  = w_cy + w_dy;
                n_acc = w_acc - ATAN_I;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i] <= 1'b0;
            end else if (i_en) begin
                r_valid[i] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[i] <= w_side;
                r_cx[i]   <= n_cx;
                r_cy[i]   <= n_cy;
                r_acc[i]  <= n_acc;
            end
        end
    end

    assign o_valid = r_valid[STEPS-1];
    assign o_side  = r_side[STEPS-1];
    assign o_angle = r_acc[STEPS-1];

endmodule

### src/accel_tilt_angle_and_duty_core.sv
// Tilt angle and LED duty core. Each transfer on i_sample carries one signed
// x/y/z accelerometer sample; each transfer on o_result carries the tilt
// atan2(y, sqrt(x^2 + z^2)) in signed centidegrees (-9000..9000, rounded to
// nearest) and three duties abs(axis)/32768 (32768 = fully on). The core is
// fully pipelined and keeps no state between samples: it takes one sample
// every clock while the output buffer has room. A sample passes through 5
// front stages, the square root (one root bit per stage, 31 stages), the
// CORDIC arctangent (one stage per iteration, 16), 2 rounding stages and the
// output buffer head. The whole pipeline holds while the two-entry output
// buffer is full; i_sample.ready stays high as long as that buffer has room,
// so the output side may stall without blocking the input for two results.
module accel_tilt_angle_and_duty_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    atad_in_if.sink           i_sample,
    atad_out_if.source        o_result
);
    import atad_pkg::*;

    typedef struct packed {
        logic signed [TILT_W-1:0] tilt;
        logic [DUTY_W-1:0]        duty_x;
        logic [DUTY_W-1:0]        duty_y;
        logic [DUTY_W-1:0]        duty_z;
    } t_result;

    logic w_adv;    // global pipeline advance

    // stage 0: zero extend, abs, duties
    logic [31:0]            w_raw_x, w_raw_y, w_raw_z;
    logic [ABS_W-1:0]       n_ax, n_ay, n_az;
    t_side                  n_side0;

    always_comb begin
        w_raw_x = {16'b0, i_sample.accel_x};
        w_raw_y = {16'b0, i_sample.accel_y};
        w_raw_z = {16'b0, i_sample.accel_z};
        n_ax    = abs_of(w_raw_x[SAMPLE_BITS-1:0]);
        n_ay    = abs_of(w_raw_y[SAMPLE_BITS-1:0]);
        n_az    = abs_of(w_raw_z[SAMPLE_BITS-1:0]);
        n_side0.neg     = w_raw_y[SAMPLE_BITS-1];
        n_side0.ay_zero = (n_ay == '0);
        n_side0.s_zero  = 1'b0;          // filled in at stage 2
        n_side0.duty_x  = duty_of(n_ax);
        n_side0.duty_y  = duty_of(n_ay);
        n_side0.duty_z  = duty_of(n_az);
    end

    logic             r0_valid;
    t_side            r0_side;
    logic [ABS_W-1:0] r0_ax, r0_ay, r0_az;

    // ---------------- stage 1: squares ----------------
    logic             r1_valid;
    t_side            r1_side;
    logic [ABS_W-1:0] r1_ay;
    logic [SQ_W-1:0]  r1_xsq, r1_ysq, r1_zsq;

    // ---------------- stage 2: sums ----------------
    logic             r2_valid;
    t_side            r2_side;
    logic [ABS_W-1:0] r2_ay;
    logic [SUM_W-1:0] r2_s;
    logic [MAG_W-1:0] r2_m;
    logic [SUM_W-1:0] n_s;
    logic [MAG_W-1:0] n_m;
    t_side            n_side2;

    always_comb begin
        n_s = SUM_W'(r1_xsq) + SUM_W'(r1_zsq);
        n_m = MAG_W'(n_s) + MAG_W'(r1_ysq);
        n_side2        = r1_side;
        n_side2.s_zero = (n_s == '0);
    end

    // ---------------- stage 3: normalization count ----------------
    // k is the smallest count with m << 2k >= 2^60; from the top set bit p,
    // k = ceil((60 - p) / 2).
    logic               r3_valid;
    t_side              r3_side;
    logic [ABS_W-1:0]   r3_ay;
    logic [SUM_W-1:0]   r3_s;
    logic [SHIFT_W-1:0] r3_k;
    logic [SHIFT_W-1:0] n_k;

    always_comb begin
        n_k = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (r2_m[b]) begin
                n_k = SHIFT_W'((NORM_TOP + 1 - b) >> 1);
            end
        end
    end

    // ---------------- stage 4: apply shift ----------------
    logic              r4_valid;
    t_side             r4_side;
    logic [NORM_W-1:0] r4_n;
    logic [ROOT_W-1:0] r4_y;
    logic [NORM_W-1:0] n_n;
    logic [ROOT_W-1:0] n_y;

    always_comb begin
        n_n = NORM_W'(r3_s) << {r3_k, 1'b0};
        n_y = ROOT_W'(r3_ay) << r3_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (w_adv) begin
            r0_valid <= i_sample.valid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_side <= n_side0;
            r0_ax   <= n_ax;
            r0_ay   <= n_ay;
            r0_az   <= n_az;

            r1_side <= r0_side;
            r1_ay   <= r0_ay;
            r1_xsq  <= SQ_W'(r0_ax) * SQ_W'(r0_ax);
            r1_ysq  <= SQ_W'(r0_ay) * SQ_W'(r0_ay);
            r1_zsq  <= SQ_W'(r0_az) * SQ_W'(r0_az);

            r2_side <= n_side2;
            r2_ay   <= r1_ay;
            r2_s    <= n_s;
            r2_m    <= n_m;

            r3_side <= r2_side;
            r3_ay   <= r2_ay;
            r3_s    <= r2_s;
            r3_k    <= n_k;

            r4_side <= r3_side;
            r4_n    <= n_n;
            r4_y    <= n_y;
        end
    end

    // ---------------- square root of normalized x^2 + z^2 ----------------
    logic              w_sq_valid;
    t_side             w_sq_side;
    logic [ROOT_W-1:0] w_sq_root;
    logic [ROOT_W-1:0] w_sq_y;

    atad_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r4_valid),
        .i_side  (r4_side),
        .i_n     (r4_n),
        .i_y     (r4_y),
        .o_valid (w_sq_valid),
        .o_side  (w_sq_side),
        .o_root  (w_sq_root),
        .o_y     (w_sq_y)
    );

    // ---------------- arctangent of |y| / root ----------------
    logic                    w_cd_valid;
    t_side                   w_cd_side;
    logic signed [ANG_W-1:0] w_cd_angle;

    atad_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (w_sq_valid),
        .i_side  (w_sq_side),
        .i_root  (w_sq_root),
        .i_y     (w_sq_y),
        .o_valid (w_cd_valid),
        .o_side  (w_cd_side),
        .o_angle (w_cd_angle)
    );

    // ---------------- stage R0: clamp at zero, add half, drop 6 bits ----------------
    logic               r5_valid;
    t_side              r5_side;
    logic [DIV_Q_W-1:0] r5_t;
    logic [ANG_W-1:0]   n_pos;
    logic [ANG_W:0]     n_rnd;

    always_comb begin
        n_pos = w_cd_angle[ANG_W-1] ? '0 : $unsigned(w_cd_angle);
        n_rnd = {1'b0, n_pos} + (ANG_W + 1)'(UNITS_HALF);
    end

    // ---------------- stage R1: divide by 15625 via reciprocal ----------------
    logic              r6_valid;
    t_side             r6_side;
    logic [PROD_W-1:0] r6_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
        end else if (w_adv) begin
            r5_valid <= w_cd_valid;
            r6_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_side <= w_cd_side;
            r5_t    <= DIV_Q_W'(n_rnd >> PRE_SHIFT);
            r6_side <= r5_side;
            r6_prod <= PROD_W'(r5_t) * PROD_W'(DIV_MUL);
        end
    end

    // ---------------- result: saturate, sign, special cases ----------------
    logic [CD_W-1:0]          w_cd;
    logic [TILT_W-1:0]        w_mag;
    logic signed [TILT_W-1:0] w_tilt;
    t_result                  n_res;

    always_comb begin
        w_cd  = r6_prod[PROD_W-1:DIV_SHIFT];
        w_mag = (w_cd > CD_W'(MAX_CENTIDEG)) ? TILT_W'(MAX_CENTIDEG) : TILT_W'(w_cd);
        priority if (r6_side.ay_zero) begin
            w_tilt = '0;                         // atan2(0, r) is 0
        end else if (r6_side.s_zero) begin
            w_tilt = r6_side.neg ? TILT_MIN : TILT_MAX;   // straight up or down
        end else begin
            w_tilt = r6_side.neg ? -$signed(w_mag) : $signed(w_mag);
        end
        n_res.tilt   = w_tilt;
        n_res.duty_x = r6_side.duty_x;
        n_res.duty_y = r6_side.duty_y;
        n_res.duty_z = r6_side.duty_z;
    end

    // ---------------- two-entry output buffer ----------------
    // Head drives the port; tail catches the result that arrives while
    // the head is stalled. The pipeline holds only when both are full.
    logic [1:0] r_q_cnt;
    t_result    r_head;
    t_result    r_tail;
    logic       w_push;
    logic       w_pop;

    assign w_adv  = (r_q_cnt != 2'd2);
    assign w_push = w_adv && r6_valid;
    assign w_pop  = o_result.valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= '0;
        end else begin
            r_q_cnt <= 2'(r_q_cnt + {1'b0, w_push} - {1'b0, w_pop});
        end
    end

    // no push while full, so the two arms never meet
    always_ff @(posedge i_clk) begin
        if (w_pop && r_q_cnt == 2'd2) begin
            r_head <= r_tail;
        end else if (w_push) begin
            if (r_q_cnt == 2'd0 || w_pop) begin
                r_head <= n_res;
            end else begin
                r_tail <= n_res;
            end
        end
    end

    assign i_sample.ready         = w_adv;
    assign o_result.valid         = (r_q_cnt != 2'd0);
    assign o_result.tilt_centideg = r_head.tilt;
    assign o_result.duty_x        = r_head.duty_x;
    assign o_result.duty_y        = r_head.duty_y;
    assign o_result.duty_z        = r_head.duty_z;

endmodule

### src/atad_checker.sv
module atad_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_res_valid,
    input logic                                 i_res_ready,
    input logic signed [atad_pkg::TILT_W-1:0]   i_tilt,
    input logic [atad_pkg::DUTY_W-1:0]          i_duty_x,
    input logic [atad_pkg::DUTY_W-1:0]          i_duty_y,
    input logic [atad_pkg::DUTY_W-1:0]          i_duty_z
);
    import atad_pkg::*;

    // tilt within +-90 degrees, duties never above full scale
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_tilt >= TILT_MIN) && (i_tilt <= TILT_MAX) &&
                        ({1'b0, i_duty_x} <= DUTY_FULL) &&
                        ({1'b0, i_duty_y} <= DUTY_FULL) &&
                        ({1'b0, i_duty_z} <= DUTY_FULL))
        else $error("tilt or duty out of range");

    // level along y gives zero tilt
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_duty_y == '0) |-> (i_tilt == '0))
        else $error("zero y with nonzero tilt");

    // y only, no x or z: straight up or down
    a_vertical: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_duty_y != '0 && i_duty_x == '0 && i_duty_z == '0)
        |-> (i_tilt == TILT_MAX || i_tilt == TILT_MIN))
        else $error("vertical sample not at +-9000");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_tilt) &&
            $stable(i_duty_x) && $stable(i_duty_y) && $stable(i_duty_z)))
        else $error("stalled result changed");

endmodule

bind accel_tilt_angle_and_duty_core atad_checker u_atad_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_result.valid),
    .i_res_ready (o_result.ready),
    .i_tilt      (o_result.tilt_centideg),
    .i_duty_x    (o_result.duty_x),
    .i_duty_y    (o_result.duty_y),
    .i_duty_z    (o_result.duty_z)
);
